FILE: src/apr_pkg.sv
// shared widths, codes, types and the sine table of the point rotator
`default_nettype none
package apr_pkg;

    localparam int COORD_BITS     = 16;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int ANG_BITS       = 10;
    localparam int TAB_DEPTH      = 360;
    localparam int IDX_BITS       = 9;
    localparam int DEG_FULL       = 360;
    localparam int DEG_QUARTER    = 90;
    localparam int TRIG_BITS      = TRIG_FRAC_BITS + 2;
    localparam int U_BITS         = COORD_BITS + 1;
    localparam int PROD_BITS      = U_BITS + TRIG_BITS;
    localparam int SUM_BITS       = PROD_BITS + 1;
    localparam int QUO_BITS       = SUM_BITS - TRIG_FRAC_BITS + 1;
    localparam int TAYLOR_TERMS   = 24;

    localparam logic [1:0] OP_X    = 2'd0;
    localparam logic [1:0] OP_Y    = 2'd1;
    localparam logic [1:0] OP_Z    = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [ANG_BITS-1:0]   t_ang;
    typedef logic        [IDX_BITS-1:0]   t_idx;
    typedef logic signed [TRIG_BITS-1:0]  t_trig;
    typedef logic signed [U_BITS-1:0]     t_u;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [SUM_BITS-1:0]   t_sum;
    typedef t_trig t_sin_tab [TAB_DEPTH];

    // point and control that ride along the pipeline
    typedef struct packed {
        logic       pass;
        logic [1:0] op;
        t_coord     x;
        t_coord     y;
        t_coord     z;
    } t_meta;

    typedef struct packed {
        t_meta meta;
        t_idx  idx_s;
        t_idx  idx_c;
    } t_s1;

    typedef struct packed {
        t_meta meta;
        t_sum  first;
        t_sum  second;
    } t_s4;

    // pi in q60 and one degree in q60
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG_Q60 = PI_Q60 / 64'd180;

    // (2n)(2n+1) for the taylor series of sine
    localparam logic [63:0] TAYLOR_DEN [TAYLOR_TERMS] = '{
        64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812,
        64'd930, 64'd1056, 64'd1190, 64'd1332, 64'd1482, 64'd1640,
        64'd1806, 64'd1980, 64'd2162
    };

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // sin of k degrees for k in 0..90, rounded to the trig fraction
    function automatic t_trig quarter_sin(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = DEG_Q60 * 64'(k);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n < TAYLOR_TERMS; n++) begin
            if (term != 64'd0) begin
                term = mul_q60(term, x2) / TAYLOR_DEN[n];
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        sum = sum + (64'd1 << (59 - TRIG_FRAC_BITS));
        sum = sum >> (60 - TRIG_FRAC_BITS);
        return t_trig'(sum[TRIG_BITS-1:0]);
    endfunction

    function automatic t_sin_tab build_sin_tab();
        t_sin_tab t;
        for (int k = 0; k < TAB_DEPTH; k++) begin
            if (k <= 90) begin
                t[k] = quarter_sin(k);
            end else if (k <= 180) begin
                t[k] = quarter_sin(180 - k);
            end else if (k <= 270) begin
                t[k] = -quarter_sin(k - 180);
            end else begin
                t[k] = -quarter_sin(360 - k);
            end
        end
        return t;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

endpackage
`default_nettype wire

FILE: src/apr_if.sv
// valid/ready channel interfaces for points in and rotated points out
`default_nettype none
interface apr_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    apr_pkg::t_ang       angle_deg;
    apr_pkg::t_coord     x_in;
    apr_pkg::t_coord     y_in;
    apr_pkg::t_coord     z_in;

    modport source (output valid, op, angle_deg, x_in, y_in, z_in, input ready);
    modport sink   (input valid, op, angle_deg, x_in, y_in, z_in, output ready);
endinterface

interface apr_out_if;
    logic                valid;
    logic                ready;
    apr_pkg::t_coord     x_out;
    apr_pkg::t_coord     y_out;
    apr_pkg::t_coord     z_out;

    modport source (output valid, x_out, y_out, z_out, input ready);
    modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface
`default_nettype wire

FILE: src/axis_point_rotator_core.sv
// top level of the point rotator: rotates a 3d point about one axis
//
// i_pt carries op (axis 0 x, 1 y, 2 z, 3 none), angle_deg and the point;
// o_pt carries the rotated point, one result for every input transfer,
// in order. rotation is about the chosen axis, centred on (-1,-1,-1),
// with sine/cosine from a whole-degree table; results truncate toward
// zero and saturate. a zero angle or op 3 passes the point unchanged.
// the stages from an input transfer to o_pt.valid: angle reduction,
// table lookup, multiply, add, then scale and saturate into the output
// register. throughput is one point per cycle while o_pt takes results,
// set by the single multiply stage with four multipliers working in parallel.
// the whole pipeline advances together: when the output register holds
// a result that o_pt does not take, every stage holds and i_pt.ready
// drops in the same cycle, so nothing is lost or repeated. ready stays
// high while the output register is empty or being drained.
// synchronous reset clears all valid bits; the block is ready at once.
`default_nettype none
module axis_point_rotator_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    apr_in_if.sink     i_pt,
    apr_out_if.source  o_pt
);

    logic         en;
    logic         s1_valid;
    apr_pkg::t_s1 s1_data;
    logic         s4_valid;
    apr_pkg::t_s4 s4_data;
    logic         out_valid;

    assign en         = !out_valid || o_pt.ready;
    assign i_pt.ready = en;

    apr_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_pt.valid),
        .i_op        (i_pt.op),
        .i_angle_deg (i_pt.angle_deg),
        .i_x         (i_pt.x_in),
        .i_y         (i_pt.y_in),
        .i_z         (i_pt.z_in),
        .o_valid     (s1_valid),
        .o_data      (s1_data)
    );

    apr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_valid (s4_valid),
        .o_data  (s4_data)
    );

    apr_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s4_valid),
        .i_data  (s4_data),
        .o_valid (out_valid),
        .o_x     (o_pt.x_out),
        .o_y     (o_pt.y_out),
        .o_z     (o_pt.z_out)
    );

    assign o_pt.valid = out_valid;

endmodule
`default_nettype wire

FILE: src/apr_prep.sv
// first stage: angle reduction to table indexes and pass-through decision
`default_nettype none
module apr_prep (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [1:0]      i_op,
    input  wire apr_pkg::t_ang   i_angle_deg,
    input  wire apr_pkg::t_coord i_x,
    input  wire apr_pkg::t_coord i_y,
    input  wire apr_pkg::t_coord i_z,
    output logic                 o_valid,
    output apr_pkg::t_s1         o_data
);

    localparam int EB = apr_pkg::ANG_BITS + 1;

    logic signed [EB-1:0] ext;
    logic signed [EB-1:0] red;
    apr_pkg::t_idx        idx_s;
    apr_pkg::t_idx        idx_c;
    logic                 r_valid;
    apr_pkg::t_s1         r_data;
    apr_pkg::t_s1         n_data;

    always_comb begin
        ext = EB'(i_angle_deg);
        priority if (ext < -EB'(apr_pkg::DEG_FULL)) begin
            red = ext + EB'(2 * apr_pkg::DEG_FULL);
        end else if (ext < 0) begin
            red = ext + EB'(apr_pkg::DEG_FULL);
        end else if (ext >= EB'(apr_pkg::DEG_FULL)) begin
            red = ext - EB'(apr_pkg::DEG_FULL);
        end else begin
            red = ext;
        end
        idx_s = red[apr_pkg::IDX_BITS-1:0];
        // cosine sits a quarter turn ahead on the sine table
        if (idx_s >= apr_pkg::IDX_BITS'(apr_pkg::DEG_FULL - apr_pkg::DEG_QUARTER)) begin
            idx_c = idx_s - apr_pkg::IDX_BITS'(apr_pkg::DEG_FULL - apr_pkg::DEG_QUARTER);
        end else begin
            idx_c = idx_s + apr_pkg::IDX_BITS'(apr_pkg::DEG_QUARTER);
        end
        n_data.meta.pass = (i_angle_deg == '0) || (i_op == apr_pkg::OP_NONE);
        n_data.meta.op   = i_op;
        n_data.meta.x    = i_x;
        n_data.meta.y    = i_y;
        n_data.meta.z    = i_z;
        n_data.idx_s     = idx_s;
        n_data.idx_c     = idx_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

FILE: src/apr_mac.sv
// stages two to four: trig lookup, four products, rotation sums
`default_nettype none
module apr_mac (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire apr_pkg::t_s1 i_data,
    output logic              o_valid,
    output apr_pkg::t_s4      o_data
);

    logic [2:0]         r_valid;

    // lookup stage
    apr_pkg::t_meta     r_meta2;
    apr_pkg::t_trig     r_s;
    apr_pkg::t_trig     r_c;
    apr_pkg::t_u        r_u1;
    apr_pkg::t_u        r_u2;
    apr_pkg::t_u        n_u1;
    apr_pkg::t_u        n_u2;

    // product stage
    apr_pkg::t_meta     r_meta3;
    apr_pkg::t_prod     r_cu1;
    apr_pkg::t_prod     r_su2;
    apr_pkg::t_prod     r_su1;
    apr_pkg::t_prod     r_cu2;

    // sum stage
    apr_pkg::t_s4       r_data4;

    // the pair turned by the axis, ordered so first = c*u1 - s*u2
    always_comb begin
        unique case (i_data.meta.op)
            apr_pkg::OP_X: begin
                n_u1 = apr_pkg::t_u'(i_data.meta.y) + apr_pkg::t_u'(1);
                n_u2 = apr_pkg::t_u'(i_data.meta.z) + apr_pkg::t_u'(1);
            end
            apr_pkg::OP_Y: begin
                n_u1 = apr_pkg::t_u'(i_data.meta.z) + apr_pkg::t_u'(1);
                n_u2 = apr_pkg::t_u'(i_data.meta.x) + apr_pkg::t_u'(1);
            end
            apr_pkg::OP_Z, apr_pkg::OP_NONE: begin
                n_u1 = apr_pkg::t_u'(i_data.meta.x) + apr_pkg::t_u'(1);
                n_u2 = apr_pkg::t_u'(i_data.meta.y) + apr_pkg::t_u'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta2 <= i_data.meta;
            r_s     <= apr_pkg::SIN_TAB[i_data.idx_s];
            r_c     <= apr_pkg::SIN_TAB[i_data.idx_c];
            r_u1    <= n_u1;
            r_u2    <= n_u2;

            r_meta3 <= r_meta2;
            r_cu1   <= r_c * r_u1;
            r_su2   <= r_s * r_u2;
            r_su1   <= r_s * r_u1;
            r_cu2   <= r_c * r_u2;

            r_data4.meta   <= r_meta3;
            r_data4.first  <= apr_pkg::t_sum'(r_cu1) - apr_pkg::t_sum'(r_su2);
            r_data4.second <= apr_pkg::t_sum'(r_su1) + apr_pkg::t_sum'(r_cu2);
        end
    end

    assign o_valid = r_valid[2];
    assign o_data  = r_data4;

endmodule
`default_nettype wire

FILE: src/apr_sat.sv
// last stage: truncating scale-down, recentring, saturation, output register
`default_nettype none
module apr_sat (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire apr_pkg::t_s4 i_data,
    output logic              o_valid,
    output apr_pkg::t_coord   o_x,
    output apr_pkg::t_coord   o_y,
    output apr_pkg::t_coord   o_z
);

    localparam int QB = apr_pkg::QUO_BITS;
    localparam int CB = apr_pkg::COORD_BITS;

    logic            r_valid;
    apr_pkg::t_coord r_x;
    apr_pkg::t_coord r_y;
    apr_pkg::t_coord r_z;
    apr_pkg::t_coord n_x;
    apr_pkg::t_coord n_y;
    apr_pkg::t_coord n_z;
    apr_pkg::t_coord first;
    apr_pkg::t_coord second;

    function automatic apr_pkg::t_coord scale_sat(input apr_pkg::t_sum sum);
        apr_pkg::t_sum        adj;
        apr_pkg::t_sum        quo;
        logic signed [QB-1:0] v;
        logic signed [QB-1:0] lim_hi;
        logic signed [QB-1:0] lim_lo;
        // round toward zero: bias negatives before the arithmetic shift
        adj = sum;
        if (sum < 0) begin
            adj = sum + apr_pkg::t_sum'((1 <<< apr_pkg::TRIG_FRAC_BITS) - 1);
        end
        quo    = adj >>> apr_pkg::TRIG_FRAC_BITS;
        v      = QB'(quo) - QB'(1);
        lim_hi = QB'({1'b0, {(CB-1){1'b1}}});
        lim_lo = -lim_hi - QB'(1);
        if (v > lim_hi) begin
            v = lim_hi;
        end else if (v < lim_lo) begin
            v = lim_lo;
        end
        return v[CB-1:0];
    endfunction

    always_comb begin
        first  = scale_sat(i_data.first);
        second = scale_sat(i_data.second);
        n_x    = i_data.meta.x;
        n_y    = i_data.meta.y;
        n_z    = i_data.meta.z;
        if (!i_data.meta.pass) begin
            unique case (i_data.meta.op)
                apr_pkg::OP_X: begin
                    n_y = first;
                    n_z = second;
                end
                apr_pkg::OP_Y: begin
                    n_z = first;
                    n_x = second;
                end
                apr_pkg::OP_Z, apr_pkg::OP_NONE: begin
                    n_x = first;
                    n_y = second;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule
`default_nettype wire
